>>> rtl/bdas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdas_pkg
// Shared constants and codes for the button debounce and analog smoothing
// block.
// ----------------------------------------------------------------------------
package bdas_pkg;

  // default sizes
  localparam int unsigned BUTTONS_DEF     = 7;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // scaled analog output, full scale is 2^LEVEL_BITS - 1
  localparam int unsigned LEVEL_BITS = 10;

  // per-button confirm counter
  localparam int unsigned COUNT_W = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_DATA_W-1:0] CONFIRM_RESET = 8'd3;
  localparam logic [CFG_DATA_W-1:0] PERIOD_RESET  = 8'd10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONFIRM_SAMPLES = 8'd0,
    CFG_ANALOG_PERIOD   = 8'd1
  } cfg_idx_e;

endpackage

>>> rtl/bdas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdas interfaces
// Valid/ready channels for the input ticks, the results and the
// configuration writes.
// ----------------------------------------------------------------------------

// one tick of raw button bits and one analog sample
interface bdas_in_if #(
  parameter int unsigned BUTTONS     = bdas_pkg::BUTTONS_DEF,
  parameter int unsigned SAMPLE_BITS = bdas_pkg::SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [BUTTONS-1:0]     raw_buttons;
  logic [SAMPLE_BITS-1:0] analog_sample;

  modport source (output valid, raw_buttons, analog_sample, input ready);
  modport sink   (input valid, raw_buttons, analog_sample, output ready);
endinterface

// debounced buttons and smoothed analog level
interface bdas_out_if #(
  parameter int unsigned BUTTONS = bdas_pkg::BUTTONS_DEF
) ();
  logic                            valid;
  logic                            ready;
  logic [BUTTONS-1:0]              stable_buttons;
  logic [BUTTONS-1:0]              changed_buttons;
  logic [bdas_pkg::LEVEL_BITS-1:0] analog_level;
  logic                            analog_valid;

  modport source (output valid, stable_buttons, changed_buttons, analog_level,
                  analog_valid, input ready);
  modport sink   (input valid, stable_buttons, changed_buttons, analog_level,
                  analog_valid, output ready);
endinterface

// register writes
interface bdas_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [bdas_pkg::CFG_IDX_W-1:0]  index;
  logic [bdas_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/button_debounce_and_analog_smoothing.sv
`timescale 1ns / 1ps
// Path: an accepted input transaction passes through a stage register and then
// a result register before its result is presented.
// Throughput: one tick per cycle; the stage register still takes a tick while
// a result waits, so the input stalls only once both registers are full.
// Reset: debounced bits, counters and tick divider clear, the filter starts at
// mid scale, the level reads 0 and registers return to 3 and 10.
// ----------------------------------------------------------------------------
// button_debounce_and_analog_smoothing
// Debounces a set of buttons with per-button confirm counters and keeps an
// exponential average of an analog sample on every Nth tick.
// ----------------------------------------------------------------------------
module button_debounce_and_analog_smoothing #(
  parameter int unsigned BUTTONS     = bdas_pkg::BUTTONS_DEF,
  parameter int unsigned SAMPLE_BITS = bdas_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bdas_in_if.sink      in_i,
  bdas_out_if.source   out_o,
  bdas_cfg_if.sink     cfg_i
);
  import bdas_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] FILT_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [CFG_DATA_W-1:0] confirm_q, period_q;
  logic [CFG_DATA_W-1:0] div_q, div_inc;
  logic                  fire;
  logic [SAMPLE_BITS-1:0] filt_q, filt_new;
  logic [SAMPLE_BITS+1:0] filt_sum;

  logic                  in_acc, adv2, load2;
  logic [BUTTONS-1:0]    stable_cur, stable_next, changed;

  // stage 1 and result registers
  logic                   v1_q, upd1_q;
  logic [BUTTONS-1:0]     stable1_q, changed1_q;
  logic [SAMPLE_BITS-1:0] filt1_q;
  logic                   v2_q, upd2_q;
  logic [BUTTONS-1:0]     stable2_q, changed2_q;
  logic [LEVEL_BITS-1:0]  level_q, scaled;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q <= CONFIRM_RESET;
      period_q  <= PERIOD_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CONFIRM_SAMPLES: confirm_q <= cfg_i.data;
        CFG_ANALOG_PERIOD:   period_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign adv2       = !v2_q || out_o.ready;
  assign load2      = v1_q && adv2;
  assign in_i.ready = !v1_q || adv2;
  assign in_acc     = in_i.valid && in_i.ready;

  // button debounce
  bdas_debounce #(
    .BUTTONS (BUTTONS)
  ) u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (in_acc),
    .raw_i         (in_i.raw_buttons),
    .confirm_i     (confirm_q),
    .stable_o      (stable_cur),
    .stable_next_o (stable_next),
    .changed_o     (changed)
  );

  // tick divider and exponential average
  assign div_inc  = div_q + CFG_DATA_W'(1);
  assign fire     = (div_inc >= period_q);
  assign filt_sum = (SAMPLE_BITS+2)'({filt_q, 1'b0}) + (SAMPLE_BITS+2)'(filt_q)
                  + (SAMPLE_BITS+2)'(in_i.analog_sample);
  assign filt_new = filt_sum[SAMPLE_BITS+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= '0;
      filt_q <= FILT_RESET;
    end else if (in_acc) begin
      div_q <= fire ? '0 : div_inc;
      if (fire) begin
        filt_q <= filt_new;
      end
    end
  end

  // stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_acc) begin
      v1_q <= 1'b1;
    end else if (load2) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stable1_q  <= stable_next;
      changed1_q <= changed;
      upd1_q     <= fire;
      filt1_q    <= filt_new;
    end
  end

  // level scaling
  bdas_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .level_i  (filt1_q),
    .scaled_o (scaled)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      level_q <= '0;
    end else if (load2) begin
      v2_q <= 1'b1;
      if (upd1_q) begin
        level_q <= scaled;
      end
    end else if (out_o.ready) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      stable2_q  <= stable1_q;
      changed2_q <= changed1_q;
      upd2_q     <= upd1_q;
    end
  end

  assign out_o.valid           = v2_q;
  assign out_o.stable_buttons  = stable2_q;
  assign out_o.changed_buttons = changed2_q;
  assign out_o.analog_level    = level_q;
  assign out_o.analog_valid    = upd2_q;

  // the held level only moves when an update transaction enters the result
  a_level_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(level_q) |-> $past(load2 && upd1_q))
    else $error("analog level changed without an update");

  // changed bits are relative to the debounced state before the tick
  a_changed_ref : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ((stable1_q ^ changed1_q) == $past(stable_cur)))
    else $error("changed bits inconsistent with previous debounced state");

endmodule

>>> rtl/bdas_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdas_debounce
// Per-button confirm counters and debounced state, one update per accepted
// tick.
// ----------------------------------------------------------------------------
module bdas_debounce #(
  parameter int unsigned BUTTONS = bdas_pkg::BUTTONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [BUTTONS-1:0]                raw_i,
  input  logic [bdas_pkg::CFG_DATA_W-1:0]   confirm_i,
  output logic [BUTTONS-1:0]                stable_o,
  output logic [BUTTONS-1:0]                stable_next_o,
  output logic [BUTTONS-1:0]                changed_o
);
  import bdas_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  logic [BUTTONS-1:0] stable_q, stable_d;
  logic [BUTTONS-1:0] prev_q;
  logic [COUNT_W-1:0] cnt_q [BUTTONS];
  logic [COUNT_W-1:0] cnt_d [BUTTONS];

  // counter and state update, each button on its own
  always_comb begin
    logic [COUNT_W-1:0] inc;
    for (int b = 0; b < BUTTONS; b++) begin
      inc         = (cnt_q[b] == COUNT_MAX) ? COUNT_MAX : cnt_q[b] + COUNT_ONE;
      stable_d[b] = stable_q[b];
      cnt_d[b]    = inc;
      if ((raw_i[b] != prev_q[b]) || (raw_i[b] == stable_q[b])) begin
        cnt_d[b] = '0;
      end else if (inc >= COUNT_W'(confirm_i)) begin
        stable_d[b] = raw_i[b];
        cnt_d[b]    = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      prev_q   <= '0;
      for (int b = 0; b < BUTTONS; b++) begin
        cnt_q[b] <= '0;
      end
    end else if (en_i) begin
      stable_q <= stable_d;
      prev_q   <= raw_i;
      for (int b = 0; b < BUTTONS; b++) begin
        cnt_q[b] <= cnt_d[b];
      end
    end
  end

  assign stable_o      = stable_q;
  assign stable_next_o = stable_d;
  assign changed_o     = stable_d ^ stable_q;

endmodule

>>> rtl/bdas_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdas_scale
// Scales a filtered sample to the 10-bit level range:
// level * (2^LEVEL_BITS - 1) / (2^SAMPLE_BITS - 1), truncating.
// ----------------------------------------------------------------------------
module bdas_scale #(
  parameter int unsigned SAMPLE_BITS = bdas_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0]            level_i,
  output logic [bdas_pkg::LEVEL_BITS-1:0]   scaled_o
);
  import bdas_pkg::*;

  localparam int unsigned PW = SAMPLE_BITS + LEVEL_BITS;
  localparam int unsigned RW = SAMPLE_BITS + 3;
  localparam logic [SAMPLE_BITS:0] DIV = {1'b0, {SAMPLE_BITS{1'b1}}};

  logic [PW-1:0]          prod;
  logic [LEVEL_BITS-1:0]  q1;
  logic [RW-1:0]          rem1;
  logic [2:0]             q2;
  logic [SAMPLE_BITS:0]   rem2;
  logic                   q3;
  logic [LEVEL_BITS:0]    quot;

  // product by full scale: shift and subtract
  assign prod = {level_i, {LEVEL_BITS{1'b0}}} - PW'(level_i);

  // divide by 2^S - 1: fold the high part back into the remainder twice,
  // then one compare to finish
  assign q1   = prod[PW-1:SAMPLE_BITS];
  assign rem1 = RW'(prod[SAMPLE_BITS-1:0]) + RW'(q1);
  assign q2   = rem1[SAMPLE_BITS+2:SAMPLE_BITS];
  assign rem2 = (SAMPLE_BITS+1)'(rem1[SAMPLE_BITS-1:0]) + (SAMPLE_BITS+1)'(q2);
  assign q3   = (rem2 >= DIV);
  assign quot = (LEVEL_BITS+1)'(q1) + (LEVEL_BITS+1)'(q2) + (LEVEL_BITS+1)'(q3);

  assign scaled_o = quot[LEVEL_BITS-1:0];

endmodule

>>> bench/button_debounce_and_analog_smoothing_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_and_analog_smoothing_checker
// Watches the tick, result and register channels of the debounce block. It
// keeps its own copy of the debounce counters, the tick divider and the
// analog filter, works out the result of every accepted tick and compares the
// block's results in order, field by field.
// ----------------------------------------------------------------------------
module button_debounce_and_analog_smoothing_checker
  import bdas_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bdas_in_if   in_mon_i,
  bdas_out_if  out_mon_i,
  bdas_cfg_if  cfg_mon_i,
  output int   mismatches_o,
  output int   pending_o
);

  localparam int unsigned BUTTONS      = BUTTONS_DEF;
  localparam int unsigned SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int unsigned SAMPLE_FULL  = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned LEVEL_FULL   = (1 << LEVEL_BITS) - 1;
  localparam int unsigned FILTER_START = 1 << (SAMPLE_BITS - 1);
  localparam int unsigned COUNT_MAX    = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic [BUTTONS-1:0]    stable;
    logic [BUTTONS-1:0]    changed;
    logic [LEVEL_BITS-1:0] level;
    logic                  level_valid;
  } tick_result_t;

  // register copies
  logic [CFG_DATA_W-1:0]  confirm_q;
  logic [CFG_DATA_W-1:0]  period_q;

  // debounce and filter state
  logic [BUTTONS-1:0]     stable_q;
  logic [BUTTONS-1:0]     prev_raw_q;
  logic [COUNT_W-1:0]     confirm_cnt_q [BUTTONS];
  logic [SAMPLE_BITS-1:0] filtered_q;
  logic [7:0]             tick_div_q;
  logic [LEVEL_BITS-1:0]  level_q;

  tick_result_t expected_ticks [$];
  int fail_cnt = 0;
  int queued   = 0;

  assign mismatches_o = fail_cnt;
  assign pending_o    = queued;

  // advance the debounce and filter state by one tick
  function automatic tick_result_t debounce_and_smooth(logic [BUTTONS-1:0] raw,
                                                       logic [SAMPLE_BITS-1:0] sample);
    tick_result_t       res;
    logic [BUTTONS-1:0] was_stable;
    was_stable = stable_q;
    for (int b = 0; b < BUTTONS; b++) begin
      // a bounce or an agreeing bit restarts the count
      if (raw[b] != prev_raw_q[b] || raw[b] == stable_q[b]) begin
        confirm_cnt_q[b] = '0;
      end else begin
        if (confirm_cnt_q[b] != COUNT_W'(COUNT_MAX)) confirm_cnt_q[b]++;
        // a zero threshold behaves like one
        if (confirm_cnt_q[b] >= confirm_q) begin
          stable_q[b]      = raw[b];
          confirm_cnt_q[b] = '0;
        end
      end
    end
    prev_raw_q = raw;

    // divider, a zero period fires on every tick
    tick_div_q        = tick_div_q + 8'd1;
    res.level_valid   = 1'b0;
    if (tick_div_q >= period_q) begin
      tick_div_q      = '0;
      filtered_q      = SAMPLE_BITS'((32'(filtered_q) * 3 + 32'(sample)) / 4);
      level_q         = LEVEL_BITS'((32'(filtered_q) * LEVEL_FULL) / SAMPLE_FULL);
      res.level_valid = 1'b1;
    end

    res.stable  = stable_q;
    res.changed = stable_q ^ was_stable;
    res.level   = level_q;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // monitor register writes, ticks and results
  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    if (!rst_ni) begin
      confirm_q  = CONFIRM_RESET;
      period_q   = PERIOD_RESET;
      stable_q   = '0;
      prev_raw_q = '0;
      for (int b = 0; b < BUTTONS; b++) confirm_cnt_q[b] = '0;
      filtered_q = SAMPLE_BITS'(FILTER_START);
      tick_div_q = '0;
      level_q    = '0;
      expected_ticks.delete();
      queued     = 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_idx_e'(cfg_mon_i.index))
          CFG_CONFIRM_SAMPLES: confirm_q = cfg_mon_i.data;
          CFG_ANALOG_PERIOD:   period_q  = cfg_mon_i.data;
          default: ;
        endcase
      end

      if (in_mon_i.valid && in_mon_i.ready)
        expected_ticks.push_back(debounce_and_smooth(in_mon_i.raw_buttons,
                                                     in_mon_i.analog_sample));

      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_ticks.size() == 0) begin
          fail_cnt++;
          $error("result transaction with no tick waiting for it");
        end else begin
          want = expected_ticks.pop_front();
          check_field("stable_buttons", 32'(want.stable), 32'(out_mon_i.stable_buttons));
          check_field("changed_buttons", 32'(want.changed),
                      32'(out_mon_i.changed_buttons));
          check_field("analog_level", 32'(want.level), 32'(out_mon_i.analog_level));
          check_field("analog_valid", 32'(want.level_valid),
                      32'(out_mon_i.analog_valid));
        end
      end

      queued = expected_ticks.size();
    end
  end

endmodule

>>> bench/button_debounce_and_analog_smoothing_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_and_analog_smoothing_test
// Drives ticks of raw button bits and analog samples into the debounce block,
// mostly as held presses with bounce at their start plus some noise, across
// several threshold and period settings including the extremes. Both sides
// idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module button_debounce_and_analog_smoothing_test;
  import bdas_pkg::*;

  localparam int unsigned BUTTONS     = BUTTONS_DEF;
  localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int unsigned SAMPLE_FULL = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned RAW_FULL    = (1 << BUTTONS) - 1;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned END_CYCLES  = 10;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   pending;

  int   confirm_now   = int'(CONFIRM_RESET);
  int   calm_ticks    = 0;
  int   hold_requests = 0;
  int   hold_served   = 0;

  bdas_in_if  in_ch ();
  bdas_out_if out_ch ();
  bdas_cfg_if cfg_ch ();

  button_debounce_and_analog_smoothing u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  button_debounce_and_analog_smoothing_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .cfg_mon_i    (cfg_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, calm stretches and long requested hold-offs
  initial begin
    int r;
    int stall;
    int calm;
    calm         = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (calm > 0) begin
        calm--;
        out_ch.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          calm         = $urandom_range(30, 100);
          out_ch.ready = 1'b1;
        end else if (r < 70) begin
          out_ch.ready = 1'b1;
        end else if (r < 95) begin
          out_ch.ready = 1'b0;
        end else begin
          stall        = $urandom_range(8, 40);
          out_ch.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  // gap after a tick: mostly none or short, a few long, some calm stretches
  function automatic int next_gap();
    int r;
    if (calm_ticks > 0) begin
      calm_ticks--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_ticks = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return SAMPLE_BITS'(SAMPLE_FULL);
    return SAMPLE_BITS'($urandom_range(0, SAMPLE_FULL));
  endfunction

  // one tick transaction, entered and left at a falling edge
  task automatic send_tick(logic [BUTTONS-1:0] raw, logic [SAMPLE_BITS-1:0] smp,
                           int gap, bit ask_hold);
    in_ch.valid         = 1'b1;
    in_ch.raw_buttons   = raw;
    in_ch.analog_sample = smp;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (ask_hold) hold_requests++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // held presses with bounce at the start of each hold, plus noise ticks
  task automatic run_presses(int n, int hold_at, int pause_at);
    logic [BUTTONS-1:0] held;
    logic [BUTTONS-1:0] raw;
    int run_left;
    int run_pos;
    int gap;
    held     = '0;
    run_left = 0;
    run_pos  = 0;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_drained();
      if (run_left == 0) begin
        if ($urandom_range(0, 3) == 0) held = BUTTONS'($urandom_range(0, RAW_FULL));
        else held = held ^ BUTTONS'($urandom_range(1, RAW_FULL));
        if ($urandom_range(0, 3) == 0)
          run_left = $urandom_range(confirm_now, confirm_now + 6);
        else
          run_left = $urandom_range(0, confirm_now + 2);
        run_left = (run_left == 0) ? 1 : run_left;
        run_pos  = 0;
      end
      raw = held;
      if (run_pos < 3 && $urandom_range(0, 1) == 0)
        raw = held ^ BUTTONS'($urandom_range(1, RAW_FULL));
      if ($urandom_range(0, 19) == 0) raw = BUTTONS'($urandom_range(0, RAW_FULL));
      run_left--;
      run_pos++;
      gap = (i == n - 1 || i + 1 == pause_at) ? 1 : next_gap();
      send_tick(raw, pick_sample(), gap, i == hold_at);
    end
  endtask

  task automatic run_setting(int confirm, int period, int n, int pause_at);
    wait_drained();
    write_reg(CFG_CONFIRM_SAMPLES, CFG_DATA_W'(confirm));
    write_reg(CFG_ANALOG_PERIOD, CFG_DATA_W'(period));
    confirm_now = confirm;
    run_presses(n, -1, pause_at);
  endtask

  // stimulus and verdict
  initial begin
    logic [BUTTONS-1:0] directed_raw [20];
    in_ch.valid         = 1'b0;
    in_ch.raw_buttons   = '0;
    in_ch.analog_sample = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_CONFIRM_SAMPLES;
    cfg_ch.data         = '0;
    rst_n               = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // all pressed, all released, alternating bounce, then a held pattern
    for (int k = 0; k < 5; k++) directed_raw[k] = BUTTONS'(RAW_FULL);
    for (int k = 5; k < 10; k++) directed_raw[k] = '0;
    for (int k = 10; k < 14; k++) directed_raw[k] = (k % 2 == 0) ? 7'h55 : 7'h2a;
    for (int k = 14; k < 18; k++) directed_raw[k] = 7'h2a;
    directed_raw[18] = 7'h40;
    directed_raw[19] = 7'h01;
    for (int k = 0; k < 20; k++)
      send_tick(directed_raw[k], (k < 10) ? SAMPLE_BITS'(SAMPLE_FULL) : '0,
                (k == 19) ? 1 : next_gap(), 1'b0);

    // reset settings, with a long result hold-off
    run_presses(300, 100, -1);

    // zero threshold and zero period, then the smallest, largest and others
    run_setting(0, 0, 200, -1);
    run_setting(1, 1, 200, -1);
    run_setting(255, 255, 600, -1);
    run_setting(2, 3, 250, 125);
    run_setting(4, 2, 180, -1);
    run_setting($urandom_range(1, 12), $urandom_range(2, 20), 200, -1);

    wait_drained();
    repeat (END_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bdas_pkg.sv
rtl/bdas_if.sv
rtl/bdas_debounce.sv
rtl/bdas_scale.sv
rtl/button_debounce_and_analog_smoothing.sv
bench/button_debounce_and_analog_smoothing_checker.sv
bench/button_debounce_and_analog_smoothing_test.sv
